// ===== hw/rtl/eau_pkg.sv =====
// Shared types and codes for the effective address unit.
// Used by every module under hw/rtl except eau_ram; depends on nothing else.
`default_nettype none

package eau_pkg;

    // Register file geometry: eight data and eight address registers.
    localparam int unsigned NUM_REGS  = 16;
    localparam int unsigned REG_IDX_W = 4;
    localparam int unsigned DATA_W    = 32;

    // Packed stream widths, rounded up to whole bytes.
    localparam int unsigned IN_TDATA_W  = 112;
    localparam int unsigned OUT_TDATA_W = 104;

    // Request codes.
    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_READ    = 2'd1;
    localparam logic [1:0] REQ_RESOLVE = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_NOT_ALTER = 2'd2;

    // Location kinds.
    localparam logic [1:0] LOC_DREG = 2'd0;
    localparam logic [1:0] LOC_AREG = 2'd1;
    localparam logic [1:0] LOC_MEM  = 2'd2;
    localparam logic [1:0] LOC_IMM  = 2'd3;

    // Operand sizes.
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;
    localparam logic [1:0] SIZE_LONG = 2'd2;
    localparam logic [1:0] SIZE_BAD  = 2'd3;

    // Addressing mode field.
    localparam logic [2:0] MODE_DREG     = 3'd0;
    localparam logic [2:0] MODE_AREG     = 3'd1;
    localparam logic [2:0] MODE_IND      = 3'd2;
    localparam logic [2:0] MODE_POSTINC  = 3'd3;
    localparam logic [2:0] MODE_PREDEC   = 3'd4;
    localparam logic [2:0] MODE_DISP     = 3'd5;
    localparam logic [2:0] MODE_INDEX    = 3'd6;
    localparam logic [2:0] MODE_EXTENDED = 3'd7;

    // Register field codes under the extended mode.
    localparam logic [2:0] EXT_ABS_SHORT = 3'd0;
    localparam logic [2:0] EXT_ABS_LONG  = 3'd1;
    localparam logic [2:0] EXT_PC_DISP   = 3'd2;
    localparam logic [2:0] EXT_PC_INDEX  = 3'd3;
    localparam logic [2:0] EXT_IMMEDIATE = 3'd4;

    // Stack pointer register number (byte steps are widened to a word).
    localparam logic [2:0] SP_REG = 3'd7;

    // One input word; the last field sits in the lowest bits.
    typedef struct packed {
        logic [15:0] ext_second;
        logic [15:0] ext_first;
        logic [31:0] instr_pc;
        logic        is_write;
        logic [1:0]  operand_size;
        logic [2:0]  addr_reg;
        logic [2:0]  addr_mode;
        logic [31:0] reg_value;
        logic [3:0]  reg_index;
        logic [1:0]  req_type;
    } t_in_item;

    // One result word; the last field sits in the lowest bits.
    typedef struct packed {
        logic [31:0] next_pc;
        logic [31:0] operand_value;
        logic [31:0] address;
        logic [2:0]  location_reg;
        logic [1:0]  location_kind;
        logic [1:0]  status;
    } t_result;

    // Register file read request, issued when a word is accepted.
    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] addr_a;
        logic [REG_IDX_W-1:0] addr_b;
    } t_rd_req;

    // Register file write request from the resolve logic.
    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] addr;
        logic [DATA_W-1:0]    data;
    } t_wr_req;

endpackage

`default_nettype wire

// ===== hw/rtl/eau_ram.sv =====
// Generic RAM: one write port and two read ports with registered read data.
// Stand-alone; no package needed.
`default_nettype none

module eau_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read ports return the contents from before a same-cycle write.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/eau_regfile.sv =====
// Data and address register file: RAM, per-entry valid bits and write bypass.
// Depends on eau_pkg and eau_ram.
`default_nettype none

module eau_regfile (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire eau_pkg::t_rd_req       i_rd,
    input  wire eau_pkg::t_wr_req       i_wr,
    output logic [eau_pkg::DATA_W-1:0]  o_rd_a,
    output logic [eau_pkg::DATA_W-1:0]  o_rd_b
);
    import eau_pkg::*;

    logic [NUM_REGS-1:0] r_valid;
    logic                r_vld_a;
    logic                r_vld_b;
    logic                r_hit_a;
    logic                r_hit_b;
    logic [DATA_W-1:0]   r_byp_data;
    logic [DATA_W-1:0]   ram_a;
    logic [DATA_W-1:0]   ram_b;

    eau_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_REGS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (i_wr.en),
        .i_waddr   (i_wr.addr),
        .i_wdata   (i_wr.data),
        .i_re      (i_rd.en),
        .i_raddr_a (i_rd.addr_a),
        .i_raddr_b (i_rd.addr_b),
        .o_rdata_a (ram_a),
        .o_rdata_b (ram_b)
    );

    // Valid bits: an entry never written reads as zero after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    // Sample validity and catch a write that lands in the same cycle as the read.
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_vld_a    <= r_valid[i_rd.addr_a];
            r_vld_b    <= r_valid[i_rd.addr_b];
            r_hit_a    <= i_wr.en && (i_wr.addr == i_rd.addr_a);
            r_hit_b    <= i_wr.en && (i_wr.addr == i_rd.addr_b);
            r_byp_data <= i_wr.data;
        end
    end

    // Read data as seen after the write of the same cycle.
    always_comb begin
        o_rd_a = r_hit_a ? r_byp_data : (r_vld_a ? ram_a : '0);
        o_rd_b = r_hit_b ? r_byp_data : (r_vld_b ? ram_b : '0);
    end

endmodule

`default_nettype wire

// ===== hw/rtl/eau_calc.sv =====
// Combinational resolve logic: decodes one request and forms its result and
// any register update. Depends on eau_pkg.
`default_nettype none

module eau_calc (
    input  wire eau_pkg::t_in_item        i_item,
    input  wire logic                     i_fire,
    input  wire logic [eau_pkg::DATA_W-1:0] i_rd_a,
    input  wire logic [eau_pkg::DATA_W-1:0] i_rd_b,
    output eau_pkg::t_result              o_res,
    output eau_pkg::t_wr_req              o_wr
);
    import eau_pkg::*;

    logic [DATA_W-1:0] step;
    logic [DATA_W-1:0] disp16;
    logic [DATA_W-1:0] disp8;
    logic [DATA_W-1:0] index_val;
    logic [DATA_W-1:0] brief_term;
    logic              scale_bad;
    logic              err;
    logic [1:0]        err_code;
    logic [REG_IDX_W-1:0] areg_idx;

    // Step size by operand size; the stack pointer never steps by one byte.
    always_comb begin
        case (i_item.operand_size)
            SIZE_BYTE: step = (i_item.addr_reg == SP_REG) ? 32'd2 : 32'd1;
            SIZE_WORD: step = 32'd2;
            default:   step = 32'd4;
        endcase
    end

    // Extension word terms.
    always_comb begin
        disp16     = {{16{i_item.ext_first[15]}}, i_item.ext_first};
        disp8      = {{24{i_item.ext_first[7]}}, i_item.ext_first[7:0]};
        index_val  = i_item.ext_first[11] ? i_rd_b : {{16{i_rd_b[15]}}, i_rd_b[15:0]};
        brief_term = disp8 + index_val;
        scale_bad  = (i_item.ext_first[10:9] != 2'b00);
        areg_idx   = {1'b1, i_item.addr_reg};
    end

    // Decode and form the result.
    always_comb begin
        o_res               = '0;
        o_res.status        = ST_OK;
        o_wr                = '0;
        err                 = 1'b0;
        err_code            = ST_INVALID;
        case (i_item.req_type)
            REQ_LOAD, REQ_READ: begin
                o_res.location_kind = i_item.reg_index[3] ? LOC_AREG : LOC_DREG;
                o_res.location_reg  = i_item.reg_index[2:0];
                if (i_item.req_type == REQ_LOAD) begin
                    o_res.operand_value = i_item.reg_value;
                    o_wr.en             = i_fire;
                    o_wr.addr           = i_item.reg_index;
                    o_wr.data           = i_item.reg_value;
                end else begin
                    o_res.operand_value = i_rd_a;
                end
            end
            REQ_RESOLVE: begin
                o_res.location_kind = LOC_MEM;
                o_res.next_pc       = i_item.instr_pc;
                if (i_item.operand_size == SIZE_BAD) begin
                    err = 1'b1;
                end else begin
                    case (i_item.addr_mode)
                        MODE_DREG: begin
                            o_res.location_kind = LOC_DREG;
                            o_res.location_reg  = i_item.addr_reg;
                            case (i_item.operand_size)
                                SIZE_BYTE: o_res.operand_value = {24'd0, i_rd_a[7:0]};
                                SIZE_WORD: o_res.operand_value = {16'd0, i_rd_a[15:0]};
                                default:   o_res.operand_value = i_rd_a;
                            endcase
                        end
                        MODE_AREG: begin
                            o_res.location_kind = LOC_AREG;
                            o_res.location_reg  = i_item.addr_reg;
                            o_res.operand_value = i_rd_a;
                        end
                        MODE_IND: begin
                            o_res.address = i_rd_a;
                        end
                        MODE_POSTINC: begin
                            o_res.address = i_rd_a;
                            o_wr.en       = i_fire;
                            o_wr.addr     = areg_idx;
                            o_wr.data     = i_rd_a + step;
                        end
                        MODE_PREDEC: begin
                            o_res.address = i_rd_a - step;
                            o_wr.en       = i_fire;
                            o_wr.addr     = areg_idx;
                            o_wr.data     = i_rd_a - step;
                        end
                        MODE_DISP: begin
                            o_res.address = i_rd_a + disp16;
                            o_res.next_pc = i_item.instr_pc + 32'd2;
                        end
                        MODE_INDEX: begin
                            err           = scale_bad;
                            o_res.address = i_rd_a + brief_term;
                            o_res.next_pc = i_item.instr_pc + 32'd2;
                        end
                        default: begin
                            // Extended mode: decode errors take priority over
                            // the alterability check.
                            if (i_item.addr_reg > EXT_IMMEDIATE) begin
                                err = 1'b1;
                            end else if (i_item.addr_reg == EXT_PC_INDEX && scale_bad) begin
                                err = 1'b1;
                            end else if (i_item.is_write) begin
                                err      = 1'b1;
                                err_code = ST_NOT_ALTER;
                            end
                            o_res.next_pc = i_item.instr_pc + 32'd2;
                            case (i_item.addr_reg)
                                EXT_ABS_SHORT: o_res.address = disp16;
                                EXT_ABS_LONG: begin
                                    o_res.address = {i_item.ext_first, i_item.ext_second};
                                    o_res.next_pc = i_item.instr_pc + 32'd4;
                                end
                                EXT_PC_DISP:  o_res.address = i_item.instr_pc + disp16;
                                EXT_PC_INDEX: o_res.address = i_item.instr_pc + brief_term;
                                default: begin
                                    o_res.location_kind = LOC_IMM;
                                    case (i_item.operand_size)
                                        SIZE_BYTE: begin
                                            o_res.operand_value = {24'd0, i_item.ext_first[7:0]};
                                        end
                                        SIZE_WORD: begin
                                            o_res.operand_value = {16'd0, i_item.ext_first};
                                        end
                                        default: begin
                                            o_res.operand_value =
                                                {i_item.ext_first, i_item.ext_second};
                                            o_res.next_pc = i_item.instr_pc + 32'd4;
                                        end
                                    endcase
                                end
                            endcase
                        end
                    endcase
                end
            end
            default: begin
                err = 1'b1;
            end
        endcase

        // Error results carry only the status and an all-ones next PC.
        if (err) begin
            o_res         = '0;
            o_res.status  = err_code;
            o_res.next_pc = '1;
            o_wr          = '0;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/effective_address_unit_core.sv =====
// Effective address unit, 68000 style. Every input word is one request: load
// a register, read a register, or resolve an effective address from the mode
// and register fields and up to two extension words. Each request gives exactly
// one result word. While the receiver is ready the unit accepts one word per
// clock and delivers one result per clock. A word is captured in the input
// register when it is accepted, and its result is captured in the result
// register when the word leaves the input stage, which a stalled result
// register delays. A stalled result register holds the input stage and input
// ready drops only when both stages are full. The register file read is
// launched when a word is accepted and a same-cycle register update is
// bypassed, so post-increment and pre-decrement on back-to-back words see
// each other's updates. Registers read as zero after reset. Depends on
// eau_pkg, eau_ram, eau_regfile and eau_calc.
`default_nettype none

module effective_address_unit_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Request word.
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata fields from bit 0: req_type, reg_index, reg_value, addr_mode,
    // addr_reg, operand_size, is_write, instr_pc, ext_first, ext_second.
    input  wire logic [eau_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // Result word.
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // tdata fields from bit 0: status, location_kind, location_reg, address,
    // operand_value, next_pc.
    output logic [eau_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
    import eau_pkg::*;

    localparam int unsigned ITEM_W = $bits(t_in_item);
    localparam int unsigned RES_W  = $bits(t_result);

    t_in_item          in_item;
    t_in_item          r_item;
    logic              r_in_valid;
    t_result           r_res;
    logic              r_out_valid;
    t_result           n_res;
    t_rd_req           rd_req;
    t_wr_req           wr_req;
    logic [DATA_W-1:0] rd_a;
    logic [DATA_W-1:0] rd_b;
    logic              in_accept;
    logic              advance;

    assign in_item = s_axis_tdata[ITEM_W-1:0];

    // Handshake: the input stage moves on whenever the result register is free.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Register file read addresses come straight from the incoming word.
    always_comb begin
        rd_req.en = in_accept;
        if (in_item.req_type == REQ_LOAD || in_item.req_type == REQ_READ) begin
            rd_req.addr_a = in_item.reg_index;
        end else begin
            rd_req.addr_a = {(in_item.addr_mode != MODE_DREG), in_item.addr_reg};
        end
        rd_req.addr_b = {in_item.ext_first[15], in_item.ext_first[14:12]};
    end

    eau_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (rd_req),
        .i_wr    (wr_req),
        .o_rd_a  (rd_a),
        .o_rd_b  (rd_b)
    );

    eau_calc u_calc (
        .i_item (r_item),
        .i_fire (advance),
        .i_rd_a (rd_a),
        .i_rd_b (rd_b),
        .o_res  (n_res),
        .o_wr   (wr_req)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= in_item;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, r_res};

`ifndef SYNTHESIS
    // Register updates happen only for a request that moves to the result.
    a_wr_only_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_req.en |-> advance)
        else $error("register write without a moving request");

    // Input is refused only when both stages hold a word.
    a_ready_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid && !m_axis_tready))
        else $error("input refused with room in the pipeline");

    // An error result carries an all-ones next PC and no address or value.
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.status != ST_OK) |->
            (r_res.next_pc == '1 && r_res.address == '0 && r_res.operand_value == '0))
        else $error("malformed error result");

    // A result is shown the cycle after a word leaves the input stage.
    a_advance_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("result lost after advance");

    // No result right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_effective_address_unit_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for effective_address_unit_core: a directed pass over every mode
// and error case, then random request streams, some with random stalls on both stream sides.
// Depends on eau_pkg and the effective_address_unit_core RTL only.

module tb_effective_address_unit_core;

    import eau_pkg::*;

    // Request code that the unit must reject.
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    // Cycles with no word moving on either side before the run is declared hung.
    localparam int STALL_LIMIT = 2000;
    // Cycles to keep watching after the last result; the unit has two stages.
    localparam int TAIL_CYCLES = 8;
    localparam int IN_PAD = IN_TDATA_W - $bits(t_in_item);

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // Fields from bit 0: req_type, reg_index, reg_value, addr_mode, addr_reg,
    // operand_size, is_write, instr_pc, ext_first, ext_second.
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // Fields from bit 0: status, location_kind, location_reg, address,
    // operand_value, next_pc.
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    t_result                result_word;
    assign result_word = m_axis_tdata[$bits(t_result)-1:0];

    // Shadow register file and the queue of results still owed by the unit.
    logic [31:0]            dn_file [8];
    logic [31:0]            an_file [8];
    t_result                ea_results_due [$];

    int                     error_count = 0;
    bit                     gaps_on = 1'b1;
    int                     hold_cycles = 0;

    effective_address_unit_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        $display("[%0t] ERROR: %s", $time, msg);
        error_count++;
    endtask

    function automatic logic [31:0] sign_word(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic t_result error_result(input logic [1:0] st);
        t_result r;
        r = '0;
        r.status  = st;
        r.next_pc = '1;
        return r;
    endfunction

    // Brief extension word: sign-extended low byte plus the index register,
    // taken as a sign-extended word unless bit 11 asks for the full long.
    function automatic logic [31:0] brief_offset(input logic [15:0] ext);
        logic [31:0] xv;
        xv = ext[15] ? an_file[ext[14:12]] : dn_file[ext[14:12]];
        if (!ext[11]) begin
            xv = sign_word(xv[15:0]);
        end
        return {{24{ext[7]}}, ext[7:0]} + xv;
    endfunction

    // Computes the result of one request and applies its register side effects.
    function automatic t_result predict_ea_result(input t_in_item w);
        t_result     r;
        logic [31:0] step;
        logic [2:0]  n;
        r = '0;
        n = w.addr_reg;
        if (w.req_type == REQ_LOAD || w.req_type == REQ_READ) begin
            if (w.req_type == REQ_LOAD) begin
                if (w.reg_index[3]) begin
                    an_file[w.reg_index[2:0]] = w.reg_value;
                end else begin
                    dn_file[w.reg_index[2:0]] = w.reg_value;
                end
            end
            r.status        = ST_OK;
            r.location_kind = w.reg_index[3] ? LOC_AREG : LOC_DREG;
            r.location_reg  = w.reg_index[2:0];
            r.operand_value = w.reg_index[3] ? an_file[w.reg_index[2:0]]
                                             : dn_file[w.reg_index[2:0]];
            return r;
        end
        if (w.req_type != REQ_RESOLVE || w.operand_size == SIZE_BAD) begin
            return error_result(ST_INVALID);
        end

        // The stack pointer never steps by a single byte.
        case (w.operand_size)
            SIZE_BYTE: step = (n == SP_REG) ? 32'd2 : 32'd1;
            SIZE_WORD: step = 32'd2;
            default:   step = 32'd4;
        endcase

        r.status        = ST_OK;
        r.location_kind = LOC_MEM;
        r.next_pc       = w.instr_pc;
        case (w.addr_mode)
            MODE_DREG: begin
                r.location_kind = LOC_DREG;
                r.location_reg  = n;
                case (w.operand_size)
                    SIZE_BYTE: r.operand_value = {24'h0, dn_file[n][7:0]};
                    SIZE_WORD: r.operand_value = {16'h0, dn_file[n][15:0]};
                    default:   r.operand_value = dn_file[n];
                endcase
            end
            MODE_AREG: begin
                r.location_kind = LOC_AREG;
                r.location_reg  = n;
                r.operand_value = an_file[n];
            end
            MODE_IND: begin
                r.address = an_file[n];
            end
            MODE_POSTINC: begin
                r.address  = an_file[n];
                an_file[n] = an_file[n] + step;
            end
            MODE_PREDEC: begin
                an_file[n] = an_file[n] - step;
                r.address  = an_file[n];
            end
            MODE_DISP: begin
                r.address = an_file[n] + sign_word(w.ext_first);
                r.next_pc = w.instr_pc + 32'd2;
            end
            MODE_INDEX: begin
                if (w.ext_first[10:9] != 2'b00) begin
                    return error_result(ST_INVALID);
                end
                r.address = an_file[n] + brief_offset(w.ext_first);
                r.next_pc = w.instr_pc + 32'd2;
            end
            default: begin
                // Extended modes: decode errors take priority over alterability.
                if (n > EXT_IMMEDIATE) begin
                    return error_result(ST_INVALID);
                end
                if (n == EXT_PC_INDEX && w.ext_first[10:9] != 2'b00) begin
                    return error_result(ST_INVALID);
                end
                if (w.is_write) begin
                    return error_result(ST_NOT_ALTER);
                end
                case (n)
                    EXT_ABS_SHORT: begin
                        r.address = sign_word(w.ext_first);
                        r.next_pc = w.instr_pc + 32'd2;
                    end
                    EXT_ABS_LONG: begin
                        r.address = {w.ext_first, w.ext_second};
                        r.next_pc = w.instr_pc + 32'd4;
                    end
                    EXT_PC_DISP: begin
                        r.address = w.instr_pc + sign_word(w.ext_first);
                        r.next_pc = w.instr_pc + 32'd2;
                    end
                    EXT_PC_INDEX: begin
                        r.address = w.instr_pc + brief_offset(w.ext_first);
                        r.next_pc = w.instr_pc + 32'd2;
                    end
                    default: begin
                        r.location_kind = LOC_IMM;
                        if (w.operand_size == SIZE_LONG) begin
                            r.operand_value = {w.ext_first, w.ext_second};
                            r.next_pc       = w.instr_pc + 32'd4;
                        end else begin
                            r.operand_value = (w.operand_size == SIZE_BYTE)
                                ? {24'h0, w.ext_first[7:0]} : {16'h0, w.ext_first};
                            r.next_pc       = w.instr_pc + 32'd2;
                        end
                    end
                endcase
            end
        endcase
        return r;
    endfunction

    function automatic t_in_item make_reg_req(input logic [1:0] req, input logic [3:0] idx,
                                              input logic [31:0] val);
        t_in_item w;
        w = '0;
        w.req_type  = req;
        w.reg_index = idx;
        w.reg_value = val;
        return w;
    endfunction

    function automatic t_in_item make_resolve(input logic [2:0] mode, input logic [2:0] n,
                                              input logic [1:0] size, input logic wr,
                                              input logic [31:0] pc, input logic [15:0] e1,
                                              input logic [15:0] e2);
        t_in_item w;
        w = '0;
        w.req_type     = REQ_RESOLVE;
        w.addr_mode    = mode;
        w.addr_reg     = n;
        w.operand_size = size;
        w.is_write     = wr;
        w.instr_pc     = pc;
        w.ext_first    = e1;
        w.ext_second   = e2;
        return w;
    endfunction

    // Random request: every field starts as noise, then is steered so that most
    // resolves decode cleanly and reach the address arithmetic.
    function automatic t_in_item random_request();
        t_in_item     w;
        logic [127:0] bits;
        int           pick;
        bits = {$urandom(), $urandom(), $urandom(), $urandom()};
        w    = bits[$bits(t_in_item)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 14) begin
            w.req_type = REQ_LOAD;
            case ($urandom_range(0, 3))
                0: w.reg_value = $urandom_range(0, 16);
                1: w.reg_value = 32'hFFFF_FFFF - $urandom_range(0, 16);
                default: ;
            endcase
        end else if (pick < 22) begin
            w.req_type = REQ_READ;
        end else if (pick < 25) begin
            w.req_type = REQ_UNKNOWN;
        end else begin
            w.req_type     = REQ_RESOLVE;
            w.operand_size = ($urandom_range(0, 19) == 0) ? SIZE_BAD
                                                          : 2'($urandom_range(0, 2));
            w.is_write     = ($urandom_range(0, 3) == 0);
            if (w.addr_mode == MODE_EXTENDED && $urandom_range(0, 5) != 0) begin
                w.addr_reg = 3'($urandom_range(0, 4));
            end
            if ((w.addr_mode == MODE_INDEX ||
                 (w.addr_mode == MODE_EXTENDED && w.addr_reg == EXT_PC_INDEX)) &&
                $urandom_range(0, 4) != 0) begin
                w.ext_first[10:9] = 2'b00;
            end
            if ($urandom_range(0, 9) == 0) begin
                w.instr_pc = 32'hFFFF_FFFF - $urandom_range(0, 6);
            end
        end
        return w;
    endfunction

    // Offers one word after an optional gap and records its expected result once taken.
    task automatic send_word(input t_in_item w);
        int gap;
        gap = gaps_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{IN_PAD{1'b0}}, w};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        ea_results_due.push_back(predict_ea_result(w));
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (ea_results_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_reset_state();
        send_word(make_reg_req(REQ_READ, 4'd7, 32'h0));
        send_word(make_reg_req(REQ_READ, 4'd8, 32'h0));
    endtask

    task automatic test_register_access();
        send_word(make_reg_req(REQ_LOAD, 4'd0, 32'hFFFF_FFFF));
        send_word(make_reg_req(REQ_LOAD, 4'd15, 32'h8000_0001));
        send_word(make_reg_req(REQ_LOAD, 4'd3, 32'h1234_8000));
        send_word(make_reg_req(REQ_READ, 4'd0, 32'h0));
        send_word(make_reg_req(REQ_UNKNOWN, 4'd15, 32'hFFFF_FFFF));
    endtask

    task automatic test_direct_modes();
        send_word(make_resolve(MODE_DREG, 3'd0, SIZE_BYTE, 1'b1, 32'h0, 16'h0, 16'h0));
        send_word(make_resolve(MODE_DREG, 3'd0, SIZE_WORD, 1'b0, 32'h10, 16'h0, 16'h0));
        send_word(make_resolve(MODE_DREG, 3'd0, SIZE_LONG, 1'b0, 32'hFFFF_FFFF, 16'h0, 16'h0));
        send_word(make_resolve(MODE_AREG, 3'd7, SIZE_LONG, 1'b1, 32'h100, 16'h0, 16'h0));
    endtask

    // Post-increment and pre-decrement back to back, including the stack pointer
    // byte step and a wrap below zero.
    task automatic test_indirect_modes();
        send_word(make_resolve(MODE_POSTINC, 3'd7, SIZE_BYTE, 1'b1, 32'h0, 16'h0, 16'h0));
        send_word(make_resolve(MODE_IND, 3'd7, SIZE_WORD, 1'b1, 32'h0, 16'h0, 16'h0));
        send_word(make_resolve(MODE_PREDEC, 3'd0, SIZE_BYTE, 1'b0, 32'h0, 16'h0, 16'h0));
        send_word(make_resolve(MODE_PREDEC, 3'd0, SIZE_LONG, 1'b0, 32'h0, 16'h0, 16'h0));
    endtask

    task automatic test_displacement_index();
        send_word(make_resolve(MODE_DISP, 3'd7, SIZE_WORD, 1'b0, 32'h2000, 16'h8000, 16'h0));
        // Word index from D3 with bit 8 set, which must be ignored.
        send_word(make_resolve(MODE_INDEX, 3'd0, SIZE_WORD, 1'b0, 32'h40, 16'h3180, 16'h0));
        // Nonzero scale is rejected.
        send_word(make_resolve(MODE_INDEX, 3'd0, SIZE_WORD, 1'b0, 32'h40, 16'h3600, 16'h0));
    endtask

    task automatic test_extended_modes();
        send_word(make_resolve(MODE_EXTENDED, EXT_ABS_SHORT, SIZE_WORD, 1'b0, 32'h100,
                               16'hFFFF, 16'h0));
        send_word(make_resolve(MODE_EXTENDED, EXT_ABS_LONG, SIZE_LONG, 1'b0, 32'hFFFF_FFFE,
                               16'hFFFF, 16'h0001));
        send_word(make_resolve(MODE_EXTENDED, EXT_PC_DISP, SIZE_BYTE, 1'b0, 32'h1000,
                               16'h8000, 16'h0));
        // Long index from A7.
        send_word(make_resolve(MODE_EXTENDED, EXT_PC_INDEX, SIZE_LONG, 1'b0, 32'h1000,
                               16'hF87F, 16'h0));
        // Scale error together with a write: the decode error wins.
        send_word(make_resolve(MODE_EXTENDED, EXT_PC_INDEX, SIZE_LONG, 1'b1, 32'h1000,
                               16'h0200, 16'h0));
        send_word(make_resolve(MODE_EXTENDED, EXT_IMMEDIATE, SIZE_BYTE, 1'b0, 32'h20,
                               16'hABFF, 16'hFFFF));
        send_word(make_resolve(MODE_EXTENDED, EXT_IMMEDIATE, SIZE_WORD, 1'b0, 32'h20,
                               16'hFFFF, 16'hFFFF));
        send_word(make_resolve(MODE_EXTENDED, EXT_IMMEDIATE, SIZE_LONG, 1'b0, 32'h20,
                               16'h8001, 16'hFFFE));
        send_word(make_resolve(MODE_EXTENDED, 3'd5, SIZE_WORD, 1'b0, 32'h20, 16'h0, 16'h0));
        send_word(make_resolve(MODE_EXTENDED, EXT_ABS_SHORT, SIZE_WORD, 1'b1, 32'h20,
                               16'h0, 16'h0));
        send_word(make_resolve(MODE_IND, 3'd7, SIZE_BAD, 1'b0, 32'h20, 16'h0, 16'h0));
        send_word(make_reg_req(REQ_READ, 4'd15, 32'h0));
    endtask

    // Results are held off for a long stretch while words keep coming, so the
    // unit fills and stalls its input; then the sender waits for the backlog.
    task automatic test_backpressure();
        wait_drain();
        gaps_on     = 1'b0;
        hold_cycles = 80;
        repeat (24) send_word(random_request());
        wait_drain();
        gaps_on     = 1'b1;
    endtask

    task automatic test_random_traffic(input int count, input bit with_gaps);
        gaps_on = with_gaps;
        repeat (count) send_word(random_request());
    endtask

    // Result side: random stalls per word, or a long hold when a test asks for one.
    initial begin : result_sink
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end else if (gaps_on) begin
                stall = $urandom_range(0, 8);
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid && hold_cycles == 0) @(posedge i_clk);
        end
    end

    // Compare every delivered word with the oldest expected result.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (ea_results_due.size() == 0) begin
                flag_error($sformatf("result with nothing expected: %h", result_word));
            end else begin
                want = ea_results_due.pop_front();
                if (result_word.status !== want.status)
                    flag_error($sformatf("status got %0d want %0d",
                                         result_word.status, want.status));
                if (result_word.location_kind !== want.location_kind)
                    flag_error($sformatf("location_kind got %0d want %0d",
                                         result_word.location_kind, want.location_kind));
                if (result_word.location_reg !== want.location_reg)
                    flag_error($sformatf("location_reg got %0d want %0d",
                                         result_word.location_reg, want.location_reg));
                if (result_word.address !== want.address)
                    flag_error($sformatf("address got %h want %h",
                                         result_word.address, want.address));
                if (result_word.operand_value !== want.operand_value)
                    flag_error($sformatf("operand_value got %h want %h",
                                         result_word.operand_value, want.operand_value));
                if (result_word.next_pc !== want.next_pc)
                    flag_error($sformatf("next_pc got %h want %h",
                                         result_word.next_pc, want.next_pc));
            end
        end
    end

    // Hang detection: too long without a word moving on either side.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("FAIL");
        $finish;
    end

    initial begin : run_tests
        for (int i = 0; i < 8; i++) begin
            dn_file[i] = '0;
            an_file[i] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_register_access();
        test_direct_modes();
        test_indirect_modes();
        test_displacement_index();
        test_extended_modes();
        test_random_traffic(200, 1'b1);
        test_backpressure();
        test_random_traffic(120, 1'b0);
        test_random_traffic(160, 1'b1);

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (ea_results_due.size() != 0) begin
            flag_error($sformatf("%0d results never delivered", ea_results_due.size()));
        end
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
